@@ src/rvt_pkg.sv @@
// ----------------------------------------------------------------------------
// rvt_pkg: shared types and constants for the rigid vertex transform
// Fixed-point formats, register indexes and the beat and stage payload types.
// ----------------------------------------------------------------------------
package rvt_pkg;

   // Fixed-point formats
   localparam int COORD_WIDTH = 32;   // Q16.16 coordinates
   localparam int QUAT_WIDTH  = 18;   // Q2.16 quaternion components
   localparam int FRAC_BITS   = 16;

   // Rounded quaternion pair product (Q.16)
   localparam int PAIR_WIDTH = 2 * QUAT_WIDTH + 1 - FRAC_BITS;
   // Rotation matrix entry: holds ONE - 2*(a+b) and 2*(a+/-b) without wrap
   localparam int MAT_WIDTH  = (2 * QUAT_WIDTH - 14 > FRAC_BITS + 3) ?
                               (2 * QUAT_WIDTH - 14) : (FRAC_BITS + 3);
   localparam int PROD_WIDTH = MAT_WIDTH + COORD_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int RND_WIDTH  = SUM_WIDTH - FRAC_BITS;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = COORD_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHIFT_X = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHIFT_Y = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHIFT_Z = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAT_W  = CSR_INDEX_WIDTH'(3);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAT_X  = CSR_INDEX_WIDTH'(4);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAT_Y  = CSR_INDEX_WIDTH'(5);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAT_Z  = CSR_INDEX_WIDTH'(6);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [QUAT_WIDTH-1:0]  quat_type;
   typedef logic signed [MAT_WIDTH-1:0]   mat_entry_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;

   // Request beat
   typedef struct packed {
      coord_type in_x;
      coord_type in_y;
      coord_type in_z;
   } vertex_in_type;

   // Response beat
   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
      logic      clipped;
   } vertex_out_type;

   // Rotation matrix (row major) and translation, from the register block
   typedef struct packed {
      mat_entry_type [8:0] rot;
      coord_type     [2:0] shift;
   } xform_type;

   // Two partial sums per output row
   typedef struct packed {
      sum_type [5:0] part;
   } partial_type;

endpackage

@@ src/rvt_matrix.sv @@
// ----------------------------------------------------------------------------
// rvt_matrix: configuration registers and rotation matrix
// Holds translation and quaternion, and builds the registered 3x3 matrix.
// ----------------------------------------------------------------------------
module rvt_matrix (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_en,
   input  logic [rvt_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [rvt_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata,
   output rvt_pkg::xform_type                       xform
);

   localparam int QW     = rvt_pkg::QUAT_WIDTH;
   localparam int PW     = rvt_pkg::PAIR_WIDTH;
   localparam int MW     = rvt_pkg::MAT_WIDTH;
   localparam int FRAC   = rvt_pkg::FRAC_BITS;
   localparam int PROD_W = 2 * QW + 1;
   localparam int ONE    = 1 << FRAC;
   localparam logic signed [MW-1:0] ONE_M = MW'(ONE);

   rvt_pkg::coord_type     shift_ff [3];
   rvt_pkg::quat_type      quat_ff  [4];   // w, x, y, z
   rvt_pkg::mat_entry_type rot_in   [9];
   rvt_pkg::mat_entry_type rot_ff   [9];

   logic signed [PW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

   // Exact product, rounded to Q.16 (add half, floor)
   function automatic logic signed [PW-1:0] round_pair(input rvt_pkg::quat_type a,
                                                        input rvt_pkg::quat_type b);
      logic signed [PROD_W-1:0] prod;
      prod = PROD_W'(a) * PROD_W'(b);
      prod = prod + PROD_W'(1 << (FRAC - 1));
      return prod[PROD_W-1:FRAC];
   endfunction

   function automatic rvt_pkg::mat_entry_type ext(input logic signed [PW-1:0] v);
      return MW'(v);
   endfunction

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
         quat_ff[0]  <= QW'(ONE);
         quat_ff[1]  <= '0;
         quat_ff[2]  <= '0;
         quat_ff[3]  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rvt_pkg::REG_SHIFT_X: shift_ff[0] <= csr_wdata;
            rvt_pkg::REG_SHIFT_Y: shift_ff[1] <= csr_wdata;
            rvt_pkg::REG_SHIFT_Z: shift_ff[2] <= csr_wdata;
            rvt_pkg::REG_QUAT_W:  quat_ff[0]  <= csr_wdata[QW-1:0];
            rvt_pkg::REG_QUAT_X:  quat_ff[1]  <= csr_wdata[QW-1:0];
            rvt_pkg::REG_QUAT_Y:  quat_ff[2]  <= csr_wdata[QW-1:0];
            rvt_pkg::REG_QUAT_Z:  quat_ff[3]  <= csr_wdata[QW-1:0];
            default: ;
         endcase
      end
   end

   // Pair products
   always_comb begin
      xx = round_pair(quat_ff[1], quat_ff[1]);
      yy = round_pair(quat_ff[2], quat_ff[2]);
      zz = round_pair(quat_ff[3], quat_ff[3]);
      xy = round_pair(quat_ff[1], quat_ff[2]);
      xz = round_pair(quat_ff[1], quat_ff[3]);
      yz = round_pair(quat_ff[2], quat_ff[3]);
      wx = round_pair(quat_ff[0], quat_ff[1]);
      wy = round_pair(quat_ff[0], quat_ff[2]);
      wz = round_pair(quat_ff[0], quat_ff[3]);
   end

   // Quaternion to matrix, exact in Q.16
   always_comb begin
      rot_in[0] = ONE_M - ((ext(yy) + ext(zz)) <<< 1);
      rot_in[1] = (ext(xy) - ext(wz)) <<< 1;
      rot_in[2] = (ext(xz) + ext(wy)) <<< 1;
      rot_in[3] = (ext(xy) + ext(wz)) <<< 1;
      rot_in[4] = ONE_M - ((ext(xx) + ext(zz)) <<< 1);
      rot_in[5] = (ext(yz) - ext(wx)) <<< 1;
      rot_in[6] = (ext(xz) - ext(wy)) <<< 1;
      rot_in[7] = (ext(yz) + ext(wx)) <<< 1;
      rot_in[8] = ONE_M - ((ext(xx) + ext(yy)) <<< 1);
   end

   // Matrix register, free running; identity out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            rot_ff[k] <= (k == 0 || k == 4 || k == 8) ? ONE_M : '0;
         end
      end else begin
         for (int k = 0; k < 9; k++) begin
            rot_ff[k] <= rot_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         xform.rot[k] = rot_ff[k];
      end
      for (int i = 0; i < 3; i++) begin
         xform.shift[i] = shift_ff[i];
      end
   end

   // A pure scalar quaternion gives the identity in the next cycle
   a_scalar_quat_identity : assert property (@(posedge clock) disable iff (reset)
      (quat_ff[1] == '0 && quat_ff[2] == '0 && quat_ff[3] == '0) |=>
      (rot_ff[0] == ONE_M && rot_ff[4] == ONE_M && rot_ff[8] == ONE_M &&
       rot_ff[1] == '0 && rot_ff[2] == '0 && rot_ff[3] == '0 &&
       rot_ff[5] == '0 && rot_ff[6] == '0 && rot_ff[7] == '0))
      else $error("rvt_matrix: scalar quaternion did not give identity");

endmodule

@@ src/rvt_mac.sv @@
// ----------------------------------------------------------------------------
// rvt_mac: matrix-vector products and partial sums
// Stage 1 forms the nine entry products, stage 2 adds them in pairs with the
// translation.
// ----------------------------------------------------------------------------
module rvt_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_stall,
   input  rvt_pkg::vertex_in_type  up_data,
   input  rvt_pkg::xform_type      xform,
   output logic                    dn_valid,
   input  logic                    dn_stall,
   output rvt_pkg::partial_type    dn_data
);

   localparam int PRW  = rvt_pkg::PROD_WIDTH;
   localparam int SW   = rvt_pkg::SUM_WIDTH;
   localparam int FRAC = rvt_pkg::FRAC_BITS;

   logic s1_valid_ff, s2_valid_ff;
   logic s1_stall, s2_stall;

   rvt_pkg::coord_type    vec     [3];
   logic signed [PRW-1:0] prod_in [9];
   logic signed [PRW-1:0] prod_ff [9];
   rvt_pkg::sum_type      part_in [6];
   rvt_pkg::sum_type      part_ff [6];

   // Stall chain: a stage holds only when it is full and its successor holds
   assign s2_stall = s2_valid_ff && dn_stall;
   assign s1_stall = s1_valid_ff && s2_stall;
   assign up_stall = s1_stall;

   assign vec[0] = up_data.in_x;
   assign vec[1] = up_data.in_y;
   assign vec[2] = up_data.in_z;

   // Stage 1: r_ij * v_j
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i * 3 + j] = $signed(xform.rot[i * 3 + j]) * vec[j];
         end
      end
   end

   // Stage 2: (p0 + p1) and (p2 + t * 2^16) per row
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         part_in[2 * i]     = SW'(prod_ff[3 * i]) + SW'(prod_ff[3 * i + 1]);
         part_in[2 * i + 1] = SW'(prod_ff[3 * i + 2]) +
                              (SW'($signed(xform.shift[i])) <<< FRAC);
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (!s1_stall) s1_valid_ff <= up_valid;
         if (!s2_stall) s2_valid_ff <= s1_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (!s1_stall) prod_ff <= prod_in;
      if (!s2_stall) part_ff <= part_in;
   end

   assign dn_valid = s2_valid_ff;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         dn_data.part[k] = part_ff[k];
      end
   end

   // Backpressure reaches the input only through a full pipe
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      up_stall |-> (s1_valid_ff && s2_valid_ff && dn_stall))
      else $error("rvt_mac: upstream stalled with a bubble in the pipe");

endmodule

@@ src/rvt_finish.sv @@
// ----------------------------------------------------------------------------
// rvt_finish: final sum, rounding and saturation
// Stage 3 adds the partial sums and rounds to Q.16, stage 4 clamps to the
// coordinate range and holds the response beat.
// ----------------------------------------------------------------------------
module rvt_finish (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_stall,
   input  rvt_pkg::partial_type    up_data,
   output logic                    dn_valid,
   input  logic                    dn_stall,
   output rvt_pkg::vertex_out_type dn_data
);

   localparam int CW   = rvt_pkg::COORD_WIDTH;
   localparam int SW   = rvt_pkg::SUM_WIDTH;
   localparam int RW   = rvt_pkg::RND_WIDTH;
   localparam int FRAC = rvt_pkg::FRAC_BITS;
   localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
   localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

   logic s3_valid_ff, s4_valid_ff;
   logic s3_stall, s4_stall;

   rvt_pkg::sum_type     tot    [3];
   logic signed [RW-1:0] acc_in [3];
   logic signed [RW-1:0] acc_ff [3];
   rvt_pkg::coord_type   sat    [3];
   logic [2:0]           over;
   rvt_pkg::vertex_out_type out_in, out_ff;

   assign s4_stall = s4_valid_ff && dn_stall;
   assign s3_stall = s3_valid_ff && s4_stall;
   assign up_stall = s3_stall;

   // Stage 3: full sum plus half, floor to Q.16
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tot[i]    = up_data.part[2 * i] + up_data.part[2 * i + 1] +
                     SW'(1 << (FRAC - 1));
         acc_in[i] = tot[i][SW-1:FRAC];
      end
   end

   // Stage 4: clamp when the upper bits are not a plain sign extension
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         over[i] = !((&acc_ff[i][RW-1:CW-1]) || !(|acc_ff[i][RW-1:CW-1]));
         if (!over[i]) begin
            sat[i] = acc_ff[i][CW-1:0];
         end else if (acc_ff[i][RW-1]) begin
            sat[i] = COORD_MIN;
         end else begin
            sat[i] = COORD_MAX;
         end
      end
      out_in.out_x   = sat[0];
      out_in.out_y   = sat[1];
      out_in.out_z   = sat[2];
      out_in.clipped = |over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (!s3_stall) s3_valid_ff <= up_valid;
         if (!s4_stall) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!s3_stall) acc_ff <= acc_in;
      if (!s4_stall) out_ff <= out_in;
   end

   assign dn_valid = s4_valid_ff;
   assign dn_data  = out_ff;

   // A clipped beat carries at least one rail value
   a_clip_has_rail : assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && out_ff.clipped) |->
      (out_ff.out_x == COORD_MAX || out_ff.out_x == COORD_MIN ||
       out_ff.out_y == COORD_MAX || out_ff.out_y == COORD_MIN ||
       out_ff.out_z == COORD_MAX || out_ff.out_z == COORD_MIN))
      else $error("rvt_finish: clipped set without a saturated coordinate");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      up_stall |-> (s3_valid_ff && s4_valid_ff && dn_stall))
      else $error("rvt_finish: upstream stalled with a bubble in the pipe");

endmodule

@@ src/rigid_vertex_transform.sv @@
// ----------------------------------------------------------------------------
// rigid_vertex_transform: quaternion rotation plus translation of vertices
// Computes R*v + t per vertex beat, Q16.16 coordinates, saturated output.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one vertex (in_x, in_y, in_z) per beat, valid/stall handshake.
//  - rsp_*: one transformed vertex per beat, with clipped set when any
//    coordinate was clamped to the Q16.16 range.
//  - csr_*: write-only registers 0..2 translation, 3..6 quaternion w, x, y, z.
//    Writes go in while no beat is in flight; the matrix is rebuilt in the
//    cycle after a write, so a vertex may follow the write at once.
// Path: a beat accepted on req_* passes through five registers to rsp_*
// (input register, product stage, partial-sum stage, round stage, clamp
// register).
// Throughput: one vertex per cycle while req_stall is low; the nine products
// are separate multipliers, so nothing is shared between successive beats.
// Reset: empties the pipe, translation 0, quaternion (1, 0, 0, 0).
// Stall: when rsp_stall holds, each stage keeps its beat and bubbles close
// up; req_stall rises only once all five stages hold a beat.
// ----------------------------------------------------------------------------
module rigid_vertex_transform (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rvt_pkg::vertex_in_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rvt_pkg::vertex_out_type             rsp_data,
   input  logic                                csr_write_en,
   input  logic [rvt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rvt_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                   s0_valid_ff;
   logic                   s0_stall;
   rvt_pkg::vertex_in_type s0_data_ff;
   rvt_pkg::xform_type     xform;
   logic                   mac_stall;
   logic                   mac_valid;
   rvt_pkg::partial_type   mac_data;
   logic                   fin_stall;

   // Register block and matrix
   rvt_matrix u_matrix (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .xform        (xform)
   );

   // Stage 0: input register
   assign s0_stall  = s0_valid_ff && mac_stall;
   assign req_stall = s0_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (!s0_stall) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!s0_stall) s0_data_ff <= req_data;
   end

   // Stages 1-2: products and partial sums
   rvt_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s0_valid_ff),
      .up_stall (mac_stall),
      .up_data  (s0_data_ff),
      .xform    (xform),
      .dn_valid (mac_valid),
      .dn_stall (fin_stall),
      .dn_data  (mac_data)
   );

   // Stages 3-4: round and clamp
   rvt_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .up_valid (mac_valid),
      .up_stall (fin_stall),
      .up_data  (mac_data),
      .dn_valid (rsp_valid),
      .dn_stall (rsp_stall),
      .dn_data  (rsp_data)
   );

   // Input is held off only while the output side holds a beat
   a_req_stall_from_rsp : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && s0_valid_ff))
      else $error("rigid_vertex_transform: request stalled without output stall");

   // Reset empties the pipe
   a_reset_empties : assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !s0_valid_ff))
      else $error("rigid_vertex_transform: beat survived reset");

endmodule
